### hdl/hrhp_pkg.sv
package hrhp_pkg;

    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SLASH = 8'h2f;

    localparam int FIFO_DEPTH = 3;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // literals, lower case, padded with zeros to a power-of-two depth
    localparam logic [7:0] LIT_GET_STR [4] = '{8'h67, 8'h65, 8'h74, 8'h00};
    localparam logic [7:0] LIT_VER_STR [8] =
        '{8'h68, 8'h74, 8'h74, 8'h70, 8'h2f, 8'h31, 8'h2e, 8'h31};
    localparam logic [7:0] LIT_SCH_STR [8] =
        '{8'h68, 8'h74, 8'h74, 8'h70, 8'h3a, 8'h2f, 8'h2f, 8'h00};
    localparam logic [7:0] LIT_HOST_STR [8] =
        '{8'h68, 8'h6f, 8'h73, 8'h74, 8'h3a, 8'h00, 8'h00, 8'h00};

    localparam logic [3:0] LEN_GET  = 4'd3;
    localparam logic [3:0] LEN_VER  = 4'd8;
    localparam logic [3:0] LEN_SCH  = 4'd7;
    localparam logic [3:0] LEN_HOST = 4'd5;

    typedef enum logic [1:0] {
        LIT_METHOD,
        LIT_VERSION,
        LIT_SCHEME,
        LIT_HOST
    } t_lit;

    typedef enum logic [2:0] {
        F_METHOD,
        F_GAP_URL,
        F_SCHEME,
        F_PATH,
        F_HOST,
        F_GAP_VER,
        F_VERSION
    } t_field;

    typedef enum logic [1:0] {
        H_START,
        H_BLANK,
        H_VALUE,
        H_OTHER
    } t_hstep;

    typedef enum logic [1:0] {
        V_MORE,
        V_GOOD,
        V_BAD
    } t_verdict;

    typedef enum logic [1:0] {
        R_OTHER,
        R_PATH,
        R_HOST
    } t_role;

    typedef struct packed {
        logic       phase;
        t_field     field;
        logic [3:0] cnt;
        t_hstep     hstep;
        logic       cr;
        logic       bad;
    } t_state;

    typedef struct packed {
        t_verdict verdict;
        t_role    role;
        logic     line_done;
    } t_result;

    localparam t_state STATE_RESET = '{
        phase: 1'b0, field: F_METHOD, cnt: 4'd0, hstep: H_START, cr: 1'b0, bad: 1'b0
    };

    function automatic logic [7:0] fold(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5a) ? 8'(c + 8'd32) : c;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SP) || (c == CH_TAB);
    endfunction

    function automatic logic lit_match(input t_lit lit, input logic [3:0] pos,
                                       input logic [7:0] c);
        logic [7:0] ch;
        logic       ok;
        ch = '0;
        ok = 1'b0;
        unique case (lit)
            LIT_METHOD: begin
                ok = pos < LEN_GET;
                ch = LIT_GET_STR[pos[1:0]];
            end
            LIT_VERSION: begin
                ok = pos < LEN_VER;
                ch = LIT_VER_STR[pos[2:0]];
            end
            LIT_SCHEME: begin
                ok = pos < LEN_SCH;
                ch = LIT_SCH_STR[pos[2:0]];
            end
            LIT_HOST: begin
                ok = pos < LEN_HOST;
                ch = LIT_HOST_STR[pos[2:0]];
            end
            default: begin
                ok = 1'b0;
            end
        endcase
        return ok && (fold(c) == ch);
    endfunction

endpackage

### hdl/http_request_head_parser_core.sv
// HTTP request head parser, one byte per beat.
// Slave side: i_tvalid/i_tready/i_tdata carry one byte of the request stream.
// Master side: one result beat per input byte, in order.
//   o_tdata[1:0] verdict: 0 need more bytes, 1 complete GET request, 2 bad.
//   o_tuser      byte role: 0 other, 1 URL path byte, 2 Host value byte.
//   o_tlast      set on the LF that completes a CR LF line.
// Path: the accepted byte is held in an input register, then the parse logic
// writes its result into a 3-entry result queue that drives o_tvalid.
// Throughput: 1 byte per cycle while i_tready is high; the parse state
// updates in a single step per byte, so consecutive bytes flow back to back.
// i_tready depends only on internal occupancy, never on o_tready directly.
// When the receiver stalls, results collect in the queue and i_tready drops
// once the queue plus the byte in flight would fill it; no beat is lost.
// After any verdict the parser re-arms and the next byte starts a new request.
// Reset (i_rst_n low, synchronous) holds i_tready low, empties the queue and
// returns the parser to the start of a request line.
module http_request_head_parser_core
    import hrhp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_tvalid,
    output logic       i_tready,
    input  logic [7:0] i_tdata,   // [7:0] data_byte
    output logic       o_tvalid,
    input  logic       o_tready,
    output logic [7:0] o_tdata,   // [1:0] verdict, [7:2] zero
    output logic [1:0] o_tuser,   // [1:0] byte_role
    output logic       o_tlast
);

    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic                  in_acc;
    t_result               parse_res;
    t_result               out_res;
    logic [FIFO_CNT_W-1:0] fifo_count;
    logic [FIFO_CNT_W:0]   in_flight;

    assign in_flight = {1'b0, fifo_count} + (FIFO_CNT_W + 1)'(r_in_valid);
    assign i_tready  = i_rst_n && (in_flight < (FIFO_CNT_W + 1)'(FIFO_DEPTH));
    assign in_acc    = i_tvalid && i_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_byte <= i_tdata;
        end
    end

    hrhp_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_in_valid),
        .i_byte   (r_in_byte),
        .o_result (parse_res)
    );

    hrhp_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_in_valid),
        .i_data  (parse_res),
        .i_pop   (o_tready),
        .o_valid (o_tvalid),
        .o_data  (out_res),
        .o_count (fifo_count)
    );

    assign o_tdata = {6'b0, out_res.verdict};
    assign o_tuser = out_res.role;
    assign o_tlast = out_res.line_done;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_in_valid && fifo_count == FIFO_CNT_W'(FIFO_DEPTH) && !o_tready))
        else $error("result queue overflow");

endmodule

### hdl/hrhp_parse.sv
module hrhp_parse
    import hrhp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    output t_result    o_result
);

    t_state r_state;
    t_state n_state;
    t_state s_clear;

    always_comb begin
        s_clear       = STATE_RESET;
        s_clear.phase = r_state.phase;
    end

    always_comb begin
        logic bl;
        bl       = is_blank(i_byte);
        n_state  = r_state;
        o_result = '{verdict: V_MORE, role: R_OTHER, line_done: 1'b0};

        if (r_state.cr) begin
            if (i_byte == CH_LF) begin
                o_result.line_done = 1'b1;
                if (!r_state.phase) begin
                    if (!r_state.bad && r_state.field == F_VERSION
                            && r_state.cnt == LEN_VER) begin
                        n_state       = STATE_RESET;
                        n_state.phase = 1'b1;
                    end else begin
                        o_result.verdict = V_BAD;
                        n_state          = STATE_RESET;
                    end
                end else if (r_state.hstep == H_START && r_state.cnt == 4'd0) begin
                    o_result.verdict = V_GOOD;
                    n_state          = STATE_RESET;
                end else begin
                    n_state = s_clear;
                end
            end else begin
                o_result.verdict = V_BAD;
                n_state          = STATE_RESET;
            end
        end else if (i_byte == CH_CR) begin
            n_state.cr = 1'b1;
        end else if (i_byte == CH_LF) begin
            o_result.verdict = V_BAD;
            n_state          = STATE_RESET;
        end else if (!r_state.phase) begin
            if (!r_state.bad) begin
                unique case (r_state.field)
                    F_METHOD: begin
                        if (bl) begin
                            if (r_state.cnt != LEN_GET) begin
                                n_state.bad = 1'b1;
                            end else begin
                                n_state.field = F_GAP_URL;
                                n_state.cnt   = 4'd0;
                            end
                        end else if (!lit_match(LIT_METHOD, r_state.cnt, i_byte)) begin
                            n_state.bad = 1'b1;
                        end else begin
                            n_state.cnt = 4'(r_state.cnt + 4'd1);
                        end
                    end
                    F_GAP_URL: begin
                        if (bl) begin
                            n_state.field = F_GAP_URL;
                        end else if (i_byte == CH_SLASH) begin
                            n_state.field = F_PATH;
                            o_result.role = R_PATH;
                        end else if (lit_match(LIT_SCHEME, 4'd0, i_byte)) begin
                            n_state.field = F_SCHEME;
                            n_state.cnt   = 4'd1;
                        end else begin
                            n_state.bad = 1'b1;
                        end
                    end
                    F_SCHEME: begin
                        if (bl || !lit_match(LIT_SCHEME, r_state.cnt, i_byte)) begin
                            n_state.bad = 1'b1;
                        end else if (4'(r_state.cnt + 4'd1) >= LEN_SCH) begin
                            n_state.field = F_HOST;
                            n_state.cnt   = 4'd0;
                        end else begin
                            n_state.cnt = 4'(r_state.cnt + 4'd1);
                        end
                    end
                    F_HOST: begin
                        if (bl) begin
                            n_state.bad = 1'b1;
                        end else if (i_byte == CH_SLASH) begin
                            n_state.field = F_PATH;
                            o_result.role = R_PATH;
                        end
                    end
                    F_PATH: begin
                        if (bl) begin
                            n_state.field = F_GAP_VER;
                        end else begin
                            o_result.role = R_PATH;
                        end
                    end
                    F_GAP_VER: begin
                        if (!bl) begin
                            n_state.field = F_VERSION;
                            if (!lit_match(LIT_VERSION, 4'd0, i_byte)) begin
                                n_state.cnt = 4'd0;
                                n_state.bad = 1'b1;
                            end else begin
                                n_state.cnt = 4'd1;
                            end
                        end
                    end
                    F_VERSION: begin
                        if (!lit_match(LIT_VERSION, r_state.cnt, i_byte)) begin
                            n_state.bad = 1'b1;
                        end else begin
                            n_state.cnt = 4'(r_state.cnt + 4'd1);
                        end
                    end
                    default: begin
                        n_state.bad = 1'b1;
                    end
                endcase
            end
        end else begin
            case (r_state.hstep)
                H_START: begin
                    if (lit_match(LIT_HOST, r_state.cnt, i_byte)) begin
                        n_state.cnt = 4'(r_state.cnt + 4'd1);
                        if (4'(r_state.cnt + 4'd1) >= LEN_HOST) begin
                            n_state.hstep = H_BLANK;
                        end
                    end else begin
                        n_state.hstep = H_OTHER;
                    end
                end
                H_BLANK: begin
                    if (!bl) begin
                        n_state.hstep = H_VALUE;
                        o_result.role = R_HOST;
                    end
                end
                H_VALUE: begin
                    o_result.role = R_HOST;
                end
                default: begin
                    o_result.role = R_OTHER;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (i_valid) begin
            r_state <= n_state;
        end
    end

    a_verdict_rearms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_result.verdict != V_MORE) |=> (r_state == STATE_RESET))
        else $error("state not re-armed after verdict");

    a_line_done_clears_cr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_result.line_done) |=> !r_state.cr)
        else $error("CR still pending after completed line");

    a_headers_never_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase |-> !r_state.bad)
        else $error("bad flag set in header phase");

endmodule

### hdl/hrhp_out_fifo.sv
module hrhp_out_fifo
    import hrhp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  t_result               i_data,
    input  logic                  i_pop,
    output logic                  o_valid,
    output t_result               o_data,
    output logic [FIFO_CNT_W-1:0] o_count
);

    localparam logic [FIFO_PTR_W-1:0] PTR_LAST = FIFO_PTR_W'(FIFO_DEPTH - 1);

    t_result               r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;
    logic                  pop_ok;

    assign pop_ok  = i_pop && (r_count != '0);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : FIFO_PTR_W'(r_wr_ptr + 1'b1);
            end
            if (pop_ok) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : FIFO_PTR_W'(r_rd_ptr + 1'b1);
            end
            case ({i_push, pop_ok})
                2'b10:   r_count <= FIFO_CNT_W'(r_count + 1'b1);
                2'b01:   r_count <= FIFO_CNT_W'(r_count - 1'b1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
